// ===== rtl/core/egbw_pkg.sv =====
package egbw_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned COUNT_W     = 6;
  localparam int unsigned BYTES_W     = 17;
  localparam int unsigned CODE_W      = 2 * VALUE_W;
  localparam int unsigned SHIFT_W     = $clog2(CODE_W) + 1;
  localparam int unsigned BITPOS_W    = 3;
  localparam int unsigned STEP_W      = BITPOS_W + 1;
  localparam int unsigned MAX_BYTES   = 65536;
  localparam int unsigned CAP_RESET   = 65536;
  localparam int unsigned Q_DEPTH     = 2;
  localparam int unsigned Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W     = $clog2(Q_DEPTH + 1);
  localparam int unsigned LEN_W       = $clog2(VALUE_W) + 1;

  // Bit position of the most significant bit within a byte.
  localparam logic [BITPOS_W-1:0] BIT_MSB = 3'd7;

  typedef enum logic [1:0] {
    MODE_RAW   = 2'd0,
    MODE_UE    = 2'd1,
    MODE_SE    = 2'd2,
    MODE_ALIGN = 2'd3
  } egbw_mode_t;

  // One classified item: either an align request or a string of n bits,
  // namely the n low bits of v, most significant first.
  typedef struct packed {
    logic               align;
    logic [VALUE_W-1:0] v;
    logic [COUNT_W-1:0] n;
  } egbw_item_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic [BYTES_W-1:0] bytes_used;
    logic               last;
  } egbw_result_t;

endpackage

// ===== rtl/core/egbw_if.sv =====
interface egbw_in_if import egbw_pkg::*;;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [VALUE_W-1:0] value;
  logic [COUNT_W-1:0] bit_count;

  modport source (output valid, output mode, output value, output bit_count, input ready);
  modport sink   (input valid, input mode, input value, input bit_count, output ready);
endinterface

interface egbw_out_if import egbw_pkg::*;;
  logic               valid;
  logic               ready;
  logic [7:0]         out_byte;
  logic [BYTES_W-1:0] bytes_used;
  logic               last;

  modport source (output valid, output out_byte, output bytes_used, output last, input ready);
  modport sink   (input valid, input out_byte, input bytes_used, input last, output ready);
endinterface

interface egbw_cfg_if import egbw_pkg::*;;
  logic               valid;
  logic               ready;
  logic [BYTES_W-1:0] capacity_bytes;

  modport source (output valid, output capacity_bytes, input ready);
  modport sink   (input valid, input capacity_bytes, output ready);
endinterface

// ===== rtl/core/egbw_front.sv =====
module egbw_front import egbw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [VALUE_W-1:0] in_value,
  input  logic [COUNT_W-1:0] in_bit_count,
  output logic               push,
  output egbw_item_t         push_item,
  input  logic               q_full
);

  logic               valid_r;
  logic               align_r;
  logic               ue_r;
  logic [VALUE_W-1:0] v_r;
  logic [COUNT_W-1:0] n_r;

  logic               positive;
  logic [VALUE_W-1:0] dbl;
  logic [VALUE_W-1:0] v_nxt;
  logic [LEN_W-1:0]   len;
  logic [COUNT_W-1:0] ue_n;
  logic               take;

  // Stage one: map the value. ue(v) writes v+1 as a string of 2*len-1 bits.
  always_comb begin
    positive = (in_value != '0) && !in_value[VALUE_W-1];
    dbl      = {in_value[VALUE_W-2:0], 1'b0};
    case (egbw_mode_t'(in_mode))
      MODE_RAW: v_nxt = in_value;
      MODE_UE:  v_nxt = in_value + VALUE_W'(1);
      MODE_SE:  v_nxt = positive ? dbl : (VALUE_W'(1) - dbl);
      default:  v_nxt = in_value;
    endcase
  end

  assign in_ready = !valid_r || push;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (take) begin
      align_r <= (egbw_mode_t'(in_mode) == MODE_ALIGN);
      ue_r    <= (egbw_mode_t'(in_mode) == MODE_UE) || (egbw_mode_t'(in_mode) == MODE_SE);
      v_r     <= v_nxt;
      n_r     <= in_bit_count;
    end
  end

  // Stage two: length of the mapped value, then hand off to the queue.
  always_comb begin
    len = '0;
    for (int i = 0; i < VALUE_W; i++) begin
      if (v_r[i]) begin
        len = LEN_W'(i + 1);
      end
    end
    ue_n = (len == '0) ? '0 : COUNT_W'({len, 1'b0} - 1'b1);
  end

  assign push           = valid_r && !q_full;
  assign push_item.align = align_r;
  assign push_item.v     = v_r;
  assign push_item.n     = ue_r ? ue_n : n_r;

endmodule

// ===== rtl/core/egbw_queue.sv =====
module egbw_queue import egbw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  egbw_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       avail,
  output egbw_item_t pop_item
);

  egbw_item_t         mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;

  assign full     = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign avail    = (cnt_r != '0);
  assign pop_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/core/egbw_back.sv =====
module egbw_back import egbw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [BYTES_W-1:0] cap,
  input  logic               q_avail,
  input  egbw_item_t         q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output egbw_result_t       out_res
);

  // Item being written.
  logic                busy_r;
  logic                align_r;
  logic [CODE_W-1:0]   code_r;
  logic [COUNT_W-1:0]  rem_r;
  // Bit packer state that persists across items.
  logic [7:0]          partial_r;
  logic [BITPOS_W-1:0] bitpos_r;
  logic [BYTES_W-1:0]  bcount_r;
  // Output register.
  logic                ovalid_r;
  egbw_result_t        ores_r;

  logic [STEP_W-1:0]   free;
  logic [STEP_W-1:0]   k;
  logic [COUNT_W-1:0]  rem_nxt;
  logic [7:0]          byte_nxt;
  logic [BYTES_W-1:0]  bcount_inc;
  logic                room;
  logic                active;
  logic                emit;
  logic                fin_raw;
  logic                last_byte;
  logic                advance;
  logic                fin;
  logic                load;

  always_comb begin
    free       = {1'b0, bitpos_r} + 1'b1;
    k          = (rem_r < COUNT_W'(free)) ? STEP_W'(rem_r) : free;
    rem_nxt    = rem_r - COUNT_W'(k);
    // Code is left aligned; its leading bit lands at the current bit position.
    byte_nxt   = partial_r | (code_r[CODE_W-1 -: 8] >> (BIT_MSB - bitpos_r));
    bcount_inc = bcount_r + 1'b1;
    room       = (bcount_r < cap);
    if (align_r) begin
      active    = room && (bitpos_r != BIT_MSB);
      emit      = active;
      fin_raw   = 1'b1;
      last_byte = 1'b1;
    end else begin
      active    = room && (rem_r != '0);
      emit      = active && (k == free);
      fin_raw   = !active || (rem_nxt == '0) || (emit && (bcount_inc >= cap));
      // After a byte is closed a whole byte is free, so fewer than eight
      // remaining bits can only leave a partial byte behind.
      last_byte = (rem_nxt <= COUNT_W'(BIT_MSB)) || (bcount_inc >= cap);
    end
  end

  assign advance = busy_r && (!ovalid_r || out_ready);
  assign fin     = advance && fin_raw;
  assign load    = q_avail && (!busy_r || fin);
  assign q_pop   = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      partial_r <= '0;
      bitpos_r  <= BIT_MSB;
      bcount_r  <= '0;
      ovalid_r  <= 1'b0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
      end else if (fin) begin
        busy_r <= 1'b0;
      end
      if (advance && active) begin
        if (emit) begin
          partial_r <= '0;
          bitpos_r  <= BIT_MSB;
          bcount_r  <= bcount_inc;
        end else begin
          partial_r <= byte_nxt;
          bitpos_r  <= bitpos_r - BITPOS_W'(k);
        end
      end
      if (advance && emit) begin
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
    if (load) begin
      align_r <= q_item.align;
      rem_r   <= q_item.n;
      code_r  <= {{(CODE_W - VALUE_W){1'b0}}, q_item.v}
                 << (SHIFT_W'(CODE_W) - SHIFT_W'(q_item.n));
    end else if (advance && active && !align_r) begin
      rem_r  <= rem_nxt;
      code_r <= code_r << k;
    end
    if (advance && emit) begin
      ores_r.out_byte   <= align_r ? partial_r : byte_nxt;
      ores_r.bytes_used <= bcount_inc;
      ores_r.last       <= last_byte;
    end
  end

  assign out_valid = ovalid_r;
  assign out_res   = ores_r;

endmodule

// ===== rtl/core/exp_golomb_bit_writer_unit.sv =====
// Channel | Direction | Carries
// in_if   | sink      | mode, value, bit_count
// out_if  | source    | out_byte, bytes_used, last
// cfg_if  | sink      | capacity_bytes (always ready)
//
// An item is registered in the classify stage and then waits in a two-entry
// queue. The packer works through an item a byte at a time, with a last step for
// bits left in a partial byte; an item that writes nothing still takes a step.
// Reset is synchronous and active low; it empties the pipeline and restores
// the packer to an empty byte, a zero count and full capacity.
// A stall on out_if holds the packer; the queue fills and then in_if.ready drops.
module exp_golomb_bit_writer_unit import egbw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  egbw_in_if.sink    in_if,
  egbw_out_if.source out_if,
  egbw_cfg_if.sink   cfg_if
);

  // Capacity register. The user must write it only while the unit is idle, so
  // that no item ever sees it change mid-flight; the unit does not enforce this.
  logic [BYTES_W-1:0] cap_r;
  logic [BYTES_W-1:0] cap_eff;

  logic         push;
  egbw_item_t   push_item;
  logic         q_full;
  logic         q_pop;
  logic         q_avail;
  egbw_item_t   q_item;
  egbw_result_t res;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= BYTES_W'(CAP_RESET);
    end else if (cfg_if.valid) begin
      cap_r <= cfg_if.capacity_bytes;
    end
  end

  // A capacity above the largest stream size behaves as the largest size.
  assign cap_eff = (cap_r < BYTES_W'(MAX_BYTES)) ? cap_r : BYTES_W'(MAX_BYTES);

  // Front: maps each item onto a bit string (or an align request).
  egbw_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_if.valid),
    .in_ready     (in_if.ready),
    .in_mode      (in_if.mode),
    .in_value     (in_if.value),
    .in_bit_count (in_if.bit_count),
    .push         (push),
    .push_item    (push_item),
    .q_full       (q_full)
  );

  // Queue between classifier and packer so each side stalls on its own.
  egbw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .pop_item  (q_item)
  );

  // Back: packs MSB first within capacity, a byte per cycle unless out_if stalls.
  egbw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cap       (cap_eff),
    .q_avail   (q_avail),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_res   (res)
  );

  assign out_if.out_byte   = res.out_byte;
  assign out_if.bytes_used = res.bytes_used;
  assign out_if.last       = res.last;

endmodule

// ===== rtl/core/egbw_checker.sv =====
module egbw_checker import egbw_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [7:0]         out_byte,
  input logic [BYTES_W-1:0] bytes_used
);

  logic [BYTES_W-1:0] seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (out_valid && out_ready) begin
      seen_r <= bytes_used;
    end
  end

  // Byte counts of successive transfers step by exactly one.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> bytes_used == seen_r + 1'b1)
    else $error("bytes_used did not advance by one");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (bytes_used != '0) && (bytes_used <= BYTES_W'(MAX_BYTES)))
    else $error("bytes_used out of range");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write was not taken");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(bytes_used))
    else $error("stalled result changed");

endmodule

bind exp_golomb_bit_writer_unit egbw_checker u_egbw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .cfg_valid  (cfg_if.valid),
  .cfg_ready  (cfg_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_byte   (out_if.out_byte),
  .bytes_used (out_if.bytes_used)
);

// ===== tb/sv/egbw_stream_checker.sv =====
// Watches the three channels of the bit writer, keeps its own image of the
// packer state and compares every output byte with the oldest one predicted.
module egbw_stream_checker import egbw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  egbw_in_if   in_ch,
  egbw_out_if  out_ch,
  egbw_cfg_if  cfg_ch,
  output int   mismatches,
  output int   pending,
  output int   bytes_checked
);

  logic [BYTES_W-1:0]  capacity;
  logic [7:0]          acc_byte;
  logic [BITPOS_W-1:0] bit_pos;
  logic [BYTES_W-1:0]  byte_total;
  egbw_result_t        item_bytes[$];
  egbw_result_t        expected_bytes[$];

  function automatic int unsigned cap_now();
    return (capacity < MAX_BYTES) ? int'(capacity) : MAX_BYTES;
  endfunction

  task automatic close_byte();
    egbw_result_t r;
    byte_total++;
    r.out_byte   = acc_byte;
    r.bytes_used = byte_total;
    r.last       = 1'b0;
    item_bytes.push_back(r);
    acc_byte = '0;
    bit_pos  = BIT_MSB;
  endtask

  // Bits that would land at or past the capacity are dropped.
  task automatic pack_bit(input logic b);
    if (byte_total < cap_now()) begin
      if (b) acc_byte[bit_pos] = 1'b1;
      if (bit_pos == 0) close_byte();
      else bit_pos--;
    end
  endtask

  task automatic pack_bits(input logic [63:0] val, input int unsigned n);
    for (int i = n; i > 0; i--) pack_bit(val[i-1]);
  endtask

  task automatic pack_ue(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] vp1;
    int unsigned len;
    vp1 = v + 1'b1;
    len = 0;
    for (int b = 0; b < VALUE_W; b++) if (vp1[b]) len = b + 1;
    if (len != 0) begin
      pack_bits('0, len - 1);
      pack_bits({32'b0, vp1}, len);
    end
  endtask

  task automatic predict_item(input egbw_mode_t m, input logic [VALUE_W-1:0] v,
                              input logic [COUNT_W-1:0] n);
    logic [VALUE_W-1:0] mapped;
    item_bytes.delete();
    case (m)
      MODE_RAW: begin
        pack_bits({32'b0, v}, n);
      end
      MODE_UE: begin
        pack_ue(v);
      end
      MODE_SE: begin
        if (v != 0 && !v[VALUE_W-1]) mapped = 2 * v - 1;
        else mapped = -(2 * v);
        pack_ue(mapped);
      end
      default: begin
        if (bit_pos != BIT_MSB && byte_total < cap_now()) close_byte();
      end
    endcase
    if (item_bytes.size() > 0) item_bytes[item_bytes.size()-1].last = 1'b1;
    foreach (item_bytes[i]) expected_bytes.push_back(item_bytes[i]);
  endtask

  task automatic check_byte();
    egbw_result_t want;
    if (expected_bytes.size() == 0) begin
      $display("%0t: unexpected byte: expected none, actual %h bytes_used %0d last %b",
               $time, out_ch.out_byte, out_ch.bytes_used, out_ch.last);
      mismatches++;
    end else begin
      want = expected_bytes.pop_front();
      bytes_checked++;
      if (out_ch.out_byte !== want.out_byte) begin
        $display("%0t: out_byte mismatch: expected %h, actual %h",
                 $time, want.out_byte, out_ch.out_byte);
        mismatches++;
      end
      if (out_ch.bytes_used !== want.bytes_used) begin
        $display("%0t: bytes_used mismatch: expected %0d, actual %0d",
                 $time, want.bytes_used, out_ch.bytes_used);
        mismatches++;
      end
      if (out_ch.last !== want.last) begin
        $display("%0t: last mismatch: expected %b, actual %b",
                 $time, want.last, out_ch.last);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      capacity      = BYTES_W'(CAP_RESET);
      acc_byte      = '0;
      bit_pos       = BIT_MSB;
      byte_total    = '0;
      expected_bytes.delete();
      mismatches    = 0;
      bytes_checked = 0;
      pending       = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_byte();
      if (cfg_ch.valid && cfg_ch.ready) capacity = cfg_ch.capacity_bytes;
      if (in_ch.valid && in_ch.ready)
        predict_item(egbw_mode_t'(in_ch.mode), in_ch.value, in_ch.bit_count);
      pending = expected_bytes.size();
    end
  end

endmodule

// ===== tb/sv/exp_golomb_bit_writer_unit_test.sv =====
// Top of the bit writer testbench. It makes the clock, the reset and all the
// stimulus, and gives the verdict. Prediction and comparison live in the
// checker instance beside the block.
module exp_golomb_bit_writer_unit_test;
  import egbw_pkg::*;

  logic clk = 1'b0;
  logic rst_n;

  // The clock period is 8 units.
  always #4 clk = ~clk;

  egbw_in_if  in_ch();
  egbw_out_if out_ch();
  egbw_cfg_if cfg_ch();

  exp_golomb_bit_writer_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  int mismatches;
  int pending;
  int bytes_checked;

  egbw_stream_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .mismatches    (mismatches),
    .pending       (pending),
    .bytes_checked (bytes_checked)
  );

  // Percentages of cycles in which the sender holds back an item and the
  // receiver refuses a transfer. They change between the phases of the run.
  int tx_idle_pct = 10;
  int rx_idle_pct = 56;
  int items_sent  = 0;
  int cap_writes  = 0;

  // The receiver decides afresh at every rising edge whether it takes a
  // transfer in the next cycle. Only this process drives out_ch.ready.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Presents one item, after a random number of idle cycles, and returns at
  // the rising edge where the transfer took place. The valid line is left
  // high, so the next item may follow without a gap.
  task automatic send_item(input egbw_mode_t m, input logic [VALUE_W-1:0] v,
                           input logic [COUNT_W-1:0] n);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= m;
    in_ch.value     <= v;
    in_ch.bit_count <= n;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
  endtask

  // Stops the sender and waits until every predicted byte has come out. The
  // extra cycles cover items still in the pipeline that complete no byte, so
  // the block is idle when this returns.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  // Writes the capacity register; callers make sure the block is idle first.
  task automatic write_capacity(input logic [BYTES_W-1:0] c);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.capacity_bytes <= c;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    cap_writes++;
  endtask

  // Values are spread over all code lengths: a random right shift makes
  // short codes as common as long ones, and a few corner values and small
  // negatives are mixed in for the signed mapping.
  function automatic logic [VALUE_W-1:0] rand_value();
    logic [VALUE_W-1:0] corner[7];
    logic [VALUE_W-1:0] v;
    corner = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
               32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001};
    case ($urandom_range(9))
      0: v = corner[$urandom_range(6)];
      1: v = -($urandom >> $urandom_range(31, 8));
      default: v = $urandom >> $urandom_range(31, 0);
    endcase
    return v;
  endfunction

  task automatic send_random_item();
    int unsigned        pick;
    egbw_mode_t         m;
    logic [COUNT_W-1:0] n;
    pick = $urandom_range(99);
    n    = COUNT_W'($urandom_range(63, 0));
    if (pick < 35) begin
      m = MODE_RAW;
      // Most raw counts stay within the value; some run past 32 bits.
      if ($urandom_range(7) != 0) n = COUNT_W'($urandom_range(32, 0));
      else n = COUNT_W'($urandom_range(63, 33));
    end else if (pick < 65) begin
      m = MODE_UE;
    end else if (pick < 88) begin
      m = MODE_SE;
    end else begin
      m = MODE_ALIGN;
    end
    send_item(m, rand_value(), n);
  endtask

  // Random items with a full drain every fifty, so that the sender also
  // waits now and then for the output to run dry.
  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_random_item();
      if (i % 50 == 49) settle();
    end
  endtask

  initial begin
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.mode            <= MODE_RAW;
    in_ch.value           <= '0;
    in_ch.bit_count       <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.capacity_bytes <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items under the reset capacity. A full 32-bit raw write
    // leaves the packer on a byte boundary, so the align after it must do
    // nothing; the 33-bit write then leaves a partial byte for the next
    // align to pad out.
    send_item(MODE_RAW,   32'hFFFF_FFFF, 6'd32);
    send_item(MODE_ALIGN, 32'hFFFF_FFFF, 6'd63);
    send_item(MODE_RAW,   32'hFFFF_FFFF, 6'd0);
    send_item(MODE_RAW,   32'h0000_00A5, 6'd8);
    send_item(MODE_RAW,   32'h0000_0001, 6'd33);
    send_item(MODE_ALIGN, 32'h0000_0000, 6'd0);
    // The longest raw write pads the value with 31 leading zeros.
    send_item(MODE_RAW,   32'hFFFF_FFFF, 6'd63);
    send_item(MODE_RAW,   32'h0000_0055, 6'd7);
    // Unsigned codes: the shortest, the all-ones value that wraps to no
    // code at all, and the longest one.
    send_item(MODE_UE,    32'h0000_0000, 6'd0);
    send_item(MODE_UE,    32'hFFFF_FFFF, 6'd0);
    send_item(MODE_UE,    32'hFFFF_FFFE, 6'd63);
    send_item(MODE_UE,    32'h0000_0001, 6'd0);
    send_item(MODE_UE,    32'h0000_0002, 6'd0);
    // Signed codes: zero, plus and minus one, the most negative value that
    // maps to zero, and the most positive value and 32'h8000_0001, whose
    // mappings both give the longest code.
    send_item(MODE_SE,    32'h0000_0000, 6'd0);
    send_item(MODE_SE,    32'h0000_0001, 6'd0);
    send_item(MODE_SE,    32'hFFFF_FFFF, 6'd0);
    send_item(MODE_SE,    32'h8000_0000, 6'd0);
    send_item(MODE_SE,    32'h7FFF_FFFF, 6'd0);
    send_item(MODE_SE,    32'h8000_0001, 6'd0);
    send_item(MODE_ALIGN, 32'h0000_0000, 6'd0);
    send_item(MODE_ALIGN, 32'h0000_0000, 6'd0);
    settle();

    // A capacity just above the bytes written so far: the limit is hit
    // within a few items, later bits are dropped and aligns no longer
    // close a byte.
    write_capacity(BYTES_W'(bytes_checked + $urandom_range(4, 1)));
    run_random(30);
    settle();

    // Zero capacity drops everything.
    write_capacity('0);
    run_random(12);
    settle();

    // The largest register value stands for the full capacity.
    write_capacity({BYTES_W{1'b1}});
    run_random(100);
    settle();

    // Second profile: the sender idles often, the receiver rarely.
    tx_idle_pct = 56;
    rx_idle_pct = 10;
    write_capacity(BYTES_W'(MAX_BYTES));
    run_random(100);
    settle();

    // Last profile: no idling on either side, first with a limit that
    // will be reached in the middle of the phase, then with a large one.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_capacity(BYTES_W'(bytes_checked + $urandom_range(60, 20)));
    run_random(40);
    settle();
    write_capacity(BYTES_W'(MAX_BYTES - 1));
    run_random(48);
    settle();

    $display("Covered %0d input items under %0d capacity settings and three idle profiles.",
             items_sent, cap_writes);
    $display("Checked %0d output bytes; %0d mismatches, %0d bytes outstanding.",
             bytes_checked, mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("** exp_golomb_bit_writer_unit: PASSED **");
    end else begin
      $display("** exp_golomb_bit_writer_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog for a run that hangs, set far beyond the slowest correct run.
  initial begin
    #3200000;
    $display("Timeout with %0d bytes still outstanding.", pending);
    $display("** exp_golomb_bit_writer_unit: FAILED **");
    $finish;
  end

endmodule
